FILE: sv/gpsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpsb_pkg
// Shared widths, register indexes, reset values and constants of the
// Gaussian line-shape spectrum bin evaluator.
// ----------------------------------------------------------------------------
package gpsb_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] IDX_PEAK_ENERGY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_PEAK_INTENSITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_FWHM_REF       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_ENERGY_TOP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_BIN_COUNT      = 3'd4;

    localparam logic [19:0] RST_PEAK_ENERGY    = 20'd10592;
    localparam logic [15:0] RST_PEAK_INTENSITY = 16'd25600;
    localparam logic [15:0] RST_FWHM_REF       = 16'd512;
    localparam logic [19:0] RST_ENERGY_TOP     = 20'd32768;
    localparam logic [16:0] RST_BIN_COUNT      = 17'd4096;

    // sqrt(e) in Q12 is below 2^22, FWHM below 2^16
    localparam int DEN_W  = 38;
    localparam int PEAK_W = 39;
    localparam int PNUM_W = 51;

    localparam logic [20:0] C_Q16      = 21'd1584079;
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;
    localparam logic [15:0] EXP_FACTOR = 16'd42368;

    localparam int NUM_TERMS = 12;

    // floor(2^36 / k) for k = 1 .. 12
    localparam logic [36:0] RECIP_Q36 [NUM_TERMS] = '{
        37'd68719476736, 37'd34359738368, 37'd22906492245, 37'd17179869184,
        37'd13743895347, 37'd11453246122, 37'd9817068105,  37'd8589934592,
        37'd7635497415,  37'd6871947673,  37'd6247225157,  37'd5726623061
    };

    typedef struct packed {
        logic [DEN_W-1:0]  den;
        logic [PEAK_W-1:0] peak;
    } gpsb_derived_t;

endpackage

FILE: sv/gpsb_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpsb_div_pipe
// Pipelined restoring divider, one quotient bit per stage. The user must hold the
// divisor static while items are in flight (unenforced); the quotient must fit QUO_W bits.
// ----------------------------------------------------------------------------
module gpsb_div_pipe #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 17,
    parameter int QUO_W  = 32,
    parameter int SIDE_W = 17
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic [SIDE_W-1:0] out_side
);

    logic              vld_reg  [QUO_W];
    logic [DEN_W-1:0]  rem_reg  [QUO_W];
    logic [QUO_W-1:0]  qw_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    logic              v_in    [QUO_W];
    logic [DEN_W-1:0]  rem_in  [QUO_W];
    logic [QUO_W-1:0]  qw_in   [QUO_W];
    logic [SIDE_W-1:0] side_in [QUO_W];
    logic [DEN_W:0]    trial   [QUO_W];
    logic [DEN_W:0]    diff    [QUO_W];
    logic              qbit    [QUO_W];
    logic [DEN_W-1:0]  rem_next [QUO_W];
    logic [QUO_W-1:0]  qw_next  [QUO_W];

    always_comb
    begin
        for (int i = 0; i < QUO_W; i++)
        begin
            if (i == 0)
            begin
                v_in[i]    = in_valid;
                rem_in[i]  = DEN_W'(num[NUM_W-1:QUO_W]);
                qw_in[i]   = num[QUO_W-1:0];
                side_in[i] = in_side;
            end
            else
            begin
                v_in[i]    = vld_reg[i-1];
                rem_in[i]  = rem_reg[i-1];
                qw_in[i]   = qw_reg[i-1];
                side_in[i] = side_reg[i-1];
            end
            trial[i]    = {rem_in[i], qw_in[i][QUO_W-1]};
            diff[i]     = trial[i] - {1'b0, den};
            qbit[i]     = (trial[i] >= {1'b0, den});
            rem_next[i] = qbit[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
            qw_next[i]  = {qw_in[i][QUO_W-2:0], qbit[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUO_W; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < QUO_W; i++)
            begin
                vld_reg[i] <= v_in[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QUO_W; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                qw_reg[i]   <= qw_next[i];
                side_reg[i] <= side_in[i];
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign quo       = qw_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

FILE: sv/gpsb_exp_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpsb_exp_pipe
// exp(-y) in Q32 by a twelve-term alternating series, three stages per term:
// product and accumulate, reciprocal estimate, correction.
// ----------------------------------------------------------------------------
module gpsb_exp_pipe
    import gpsb_pkg::*;
#(
    parameter int SIDE_W = 26
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       y,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [32:0]       g,
    output logic [SIDE_W-1:0] out_side
);

    localparam int NT = NUM_TERMS;

    logic              va_reg [NT], vb_reg [NT], vc_reg [NT];
    logic [31:0]       xa_reg [NT], xb_reg [NT];
    logic [31:0]       ya_reg [NT], yb_reg [NT], yc_reg [NT];
    logic [33:0]       suma_reg [NT], sumb_reg [NT], sumc_reg [NT];
    logic [SIDE_W-1:0] sidea_reg [NT], sideb_reg [NT], sidec_reg [NT];
    logic [31:0]       est_reg [NT];
    logic [32:0]       term_reg [NT];
    logic              vf_reg;
    logic [33:0]       g_reg;
    logic [SIDE_W-1:0] sidef_reg;

    logic              v_in    [NT];
    logic [31:0]       y_in    [NT];
    logic [32:0]       term_in [NT];
    logic [33:0]       sum_in  [NT];
    logic [SIDE_W-1:0] side_in [NT];
    logic [64:0]       prod_a  [NT];
    logic [33:0]       sum_next [NT];
    logic [68:0]       prod_b  [NT];
    logic [35:0]       est_k   [NT];
    logic [35:0]       rmd     [NT];
    logic [32:0]       term_next [NT];
    logic [33:0]       g_next;

    always_comb
    begin
        for (int k = 0; k < NT; k++)
        begin
            if (k == 0)
            begin
                v_in[k]    = in_valid;
                y_in[k]    = y;
                term_in[k] = {1'b1, 32'd0};
                sum_in[k]  = 34'd0;
                side_in[k] = in_side;
            end
            else
            begin
                v_in[k]    = vc_reg[k-1];
                y_in[k]    = yc_reg[k-1];
                term_in[k] = term_reg[k-1];
                sum_in[k]  = sumc_reg[k-1];
                side_in[k] = sidec_reg[k-1];
            end
            prod_a[k] = 65'(term_in[k]) * 65'(y_in[k]);
            if ((k % 2) == 1)
            begin
                sum_next[k] = sum_in[k] - 34'(term_in[k]);
            end
            else
            begin
                sum_next[k] = sum_in[k] + 34'(term_in[k]);
            end
            prod_b[k] = 69'(xa_reg[k]) * 69'(RECIP_Q36[k]);
            est_k[k]  = 36'(est_reg[k]) * 36'(k + 1);
            rmd[k]    = {4'd0, xb_reg[k]} - est_k[k];
            if (rmd[k] >= 36'(k + 1))
            begin
                term_next[k] = 33'(est_reg[k]) + 33'd1;
            end
            else
            begin
                term_next[k] = 33'(est_reg[k]);
            end
        end
        if ((NT % 2) == 1)
        begin
            g_next = sumc_reg[NT-1] - 34'(term_reg[NT-1]);
        end
        else
        begin
            g_next = sumc_reg[NT-1] + 34'(term_reg[NT-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NT; k++)
            begin
                va_reg[k] <= 1'b0;
                vb_reg[k] <= 1'b0;
                vc_reg[k] <= 1'b0;
            end
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k < NT; k++)
            begin
                va_reg[k] <= v_in[k];
                vb_reg[k] <= va_reg[k];
                vc_reg[k] <= vb_reg[k];
            end
            vf_reg <= vc_reg[NT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NT; k++)
            begin
                xa_reg[k]    <= prod_a[k][63:32];
                ya_reg[k]    <= y_in[k];
                suma_reg[k]  <= sum_next[k];
                sidea_reg[k] <= side_in[k];

                est_reg[k]   <= prod_b[k][67:36];
                xb_reg[k]    <= xa_reg[k];
                yb_reg[k]    <= ya_reg[k];
                sumb_reg[k]  <= suma_reg[k];
                sideb_reg[k] <= sidea_reg[k];

                term_reg[k]  <= term_next[k];
                yc_reg[k]    <= yb_reg[k];
                sumc_reg[k]  <= sumb_reg[k];
                sidec_reg[k] <= sideb_reg[k];
            end
            g_reg     <= g_next;
            sidef_reg <= sidec_reg[NT-1];
        end
    end

    assign out_valid = vf_reg;
    assign g         = g_reg[32:0];
    assign out_side  = sidef_reg;

endmodule

FILE: sv/gpsb_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpsb_setup
// Sequencer for the per-line values: sqrt of the energy, the width
// denominator and the peak height, one step per cycle after reset or a write.
// ----------------------------------------------------------------------------
module gpsb_setup
    import gpsb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write,
    input  logic [19:0]   e_eff,
    input  logic [15:0]   f_eff,
    input  logic [15:0]   intensity,
    output logic          busy,
    output gpsb_derived_t derived
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQRT,
        ST_MUL,
        ST_DIV
    } state_t;

    state_t            state_reg;
    logic [43:0]       v_reg;
    logic [43:0]       r_reg;
    logic [43:0]       bit_reg;
    logic [5:0]        cnt_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [PNUM_W-1:0] numq_reg;
    logic [PEAK_W-1:0] peak_reg;

    logic [43:0]       sq_sum;
    logic              sq_take;
    logic [DEN_W:0]    trial;
    logic              qbit;
    logic [DEN_W:0]    diff;
    logic [PNUM_W-1:0] numq_next;

    assign sq_sum    = r_reg + bit_reg;
    assign sq_take   = (v_reg >= sq_sum);
    assign trial     = {rem_reg, numq_reg[PNUM_W-1]};
    assign diff      = trial - {1'b0, den_reg};
    assign qbit      = (trial >= {1'b0, den_reg});
    assign numq_next = {numq_reg[PNUM_W-2:0], qbit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else if (cfg_write)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_LOAD:
                begin
                    v_reg     <= {e_eff, 24'd0};
                    r_reg     <= 44'd0;
                    bit_reg   <= {2'b01, 42'd0};
                    cnt_reg   <= 6'd0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (sq_take)
                    begin
                        v_reg <= v_reg - sq_sum;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd21)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    den_reg   <= DEN_W'(f_eff) * DEN_W'(r_reg[21:0]);
                    numq_reg  <= {37'(C_Q16) * 37'(intensity), 14'd0};
                    rem_reg   <= '0;
                    cnt_reg   <= 6'd0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg  <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    numq_reg <= numq_next;
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(PNUM_W - 1))
                    begin
                        peak_reg  <= numq_next[PEAK_W-1:0];
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign derived.den  = den_reg;
    assign derived.peak = peak_reg;

endmodule

FILE: sv/gaussian_peak_spectrum_bin.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_peak_spectrum_bin
// Gaussian line-shape evaluator: one spectrum bin per item, one item per cycle.
//
// Input stream s_*: tdata[15:0] is the bin index. Output stream m_*: tdata
// holds the amplitude (2^-16 percent per keV, saturating) and the bin index,
// tuser the out-of-range flag. Configuration goes through cfg_wen, cfg_index
// and cfg_wdata; a write lands at the clock edge where cfg_wen is high.
// Each item passes through the two bit-serial divider pipelines (32 and 18
// stages) and the 37-stage exponential series, with registers between them.
// Throughput is one item per cycle while s_tready is high.
// After reset and after every configuration write a setup sequencer works
// through the square root and the peak-height division; s_tready stays
// low during that time. Reset loads the default line (662 keV).
// A two-entry output buffer lets the pipeline advance while a result waits;
// when both entries are full the whole pipeline holds and s_tready drops.
// ----------------------------------------------------------------------------
module gaussian_peak_spectrum_bin
    import gpsb_pkg::*;
#(
    parameter int MAX_BINS = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] bin_index
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // [31:0] amplitude, [47:32] bin_echo
    output logic                  m_tuser    // [0] out_of_range
);

    localparam int NB_W = $clog2(MAX_BINS + 1);

    logic [19:0] peak_energy_reg;
    logic [15:0] peak_intensity_reg;
    logic [15:0] fwhm_ref_reg;
    logic [19:0] energy_top_reg;
    logic [16:0] bin_count_reg;

    logic [19:0]      e_eff;
    logic [15:0]      f_eff;
    logic [NB_W-1:0]  n_eff;
    logic             busy;
    gpsb_derived_t    derived;

    logic adv;
    logic accept;
    logic oor_in;

    // stage 0
    logic        v0_reg;
    logic [36:0] m0_reg;
    logic [16:0] side0_reg;

    // first divider
    logic        v1;
    logic [31:0] c1;
    logic [16:0] side1;

    logic [31:0] p_energy;
    logic [31:0] xq_next;
    logic        va_reg, vb_reg;
    logic [31:0] xqa_reg, xqb_reg;
    logic [16:0] sidea_reg, sideb_reg;
    logic        ovfb_reg;

    // second divider
    logic        v2;
    logic [17:0] w2;
    logic [17:0] side2;

    logic        vc_reg, vd_reg, ve_reg;
    logic [35:0] wsq_reg;
    logic [17:0] sidec_reg, sided_reg;
    logic [51:0] t_prod;
    logic [23:0] t16_reg;
    logic [47:0] y_prod;
    logic [31:0] y_reg;
    logic [25:0] sidee_reg;

    // exponential
    logic        v3;
    logic [32:0] g3;
    logic [25:0] side3;

    logic        vf_reg, vg_reg;
    logic [24:0] g24;
    logic [44:0] plo_reg;
    logic [43:0] phi_reg;
    logic [25:0] sidef_reg, sideg_reg;
    logic [63:0] prod_reg;

    logic [8:0]  shift_amt;
    logic [63:0] shifted;
    logic [31:0] amp_next;

    // output buffer
    logic [1:0]  cnt_reg;
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [31:0] amp_buf_reg [2];
    logic [15:0] bin_buf_reg [2];
    logic        oor_buf_reg [2];
    logic        push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_energy_reg    <= RST_PEAK_ENERGY;
            peak_intensity_reg <= RST_PEAK_INTENSITY;
            fwhm_ref_reg       <= RST_FWHM_REF;
            energy_top_reg     <= RST_ENERGY_TOP;
            bin_count_reg      <= RST_BIN_COUNT;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                IDX_PEAK_ENERGY:    peak_energy_reg    <= cfg_wdata[19:0];
                IDX_PEAK_INTENSITY: peak_intensity_reg <= cfg_wdata[15:0];
                IDX_FWHM_REF:       fwhm_ref_reg       <= cfg_wdata[15:0];
                IDX_ENERGY_TOP:     energy_top_reg     <= cfg_wdata[19:0];
                IDX_BIN_COUNT:      bin_count_reg      <= 17'(cfg_wdata);
                default:            ;
            endcase
        end
    end

    assign e_eff = (peak_energy_reg == 20'd0) ? 20'd1 : peak_energy_reg;
    assign f_eff = (fwhm_ref_reg == 16'd0) ? 16'd1 : fwhm_ref_reg;
    assign n_eff = (bin_count_reg > 17'(MAX_BINS)) ? NB_W'(MAX_BINS)
                                                    : NB_W'(bin_count_reg);

    gpsb_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_wen),
        .e_eff     (e_eff),
        .f_eff     (f_eff),
        .intensity (peak_intensity_reg),
        .busy      (busy),
        .derived   (derived)
    );

    assign adv      = (cnt_reg != 2'd2);
    assign s_tready = adv & ~busy;
    assign accept   = s_tvalid & s_tready;
    assign oor_in   = ({1'b0, s_tdata} >= 17'(n_eff));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= accept;
            va_reg <= v1;
            vb_reg <= va_reg;
            vc_reg <= v2;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= v3;
            vg_reg <= vf_reg;
        end
    end

    assign p_energy = {e_eff, 12'd0};
    assign xq_next  = (c1 >= p_energy) ? (c1 - p_energy) : (p_energy - c1);
    assign t_prod   = 52'(wsq_reg) * 52'(EXP_FACTOR);
    assign y_prod   = 48'(t16_reg[15:0]) * 48'(LN2_Q32);
    assign g24      = g3[32:8];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m0_reg    <= 37'(energy_top_reg) * 37'({s_tdata, 1'b1});
            side0_reg <= {oor_in, s_tdata};

            xqa_reg   <= xq_next;
            sidea_reg <= side1;

            xqb_reg   <= xqa_reg;
            ovfb_reg  <= ({xqa_reg, 8'd0} >= 40'(derived.den));
            sideb_reg <= sidea_reg;

            wsq_reg   <= 36'(w2) * 36'(w2);
            sidec_reg <= side2;

            t16_reg   <= t_prod[51:28];
            sided_reg <= sidec_reg;

            y_reg     <= y_prod[47:16];
            sidee_reg <= {t16_reg[23:16], sided_reg};

            plo_reg   <= 45'(derived.peak[19:0]) * 45'(g24);
            phi_reg   <= 44'(derived.peak[PEAK_W-1:20]) * 44'(g24);
            sidef_reg <= side3;

            prod_reg  <= (64'(phi_reg) << 20) + 64'(plo_reg);
            sideg_reg <= sidef_reg;
        end
    end

    gpsb_div_pipe #(
        .NUM_W  (48),
        .DEN_W  (NB_W),
        .QUO_W  (32),
        .SIDE_W (17)
    ) u_div_centre (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v0_reg),
        .num       ({m0_reg, 11'd0}),
        .den       (n_eff),
        .in_side   (side0_reg),
        .out_valid (v1),
        .quo       (c1),
        .out_side  (side1)
    );

    gpsb_div_pipe #(
        .NUM_W  (58),
        .DEN_W  (DEN_W),
        .QUO_W  (18),
        .SIDE_W (18)
    ) u_div_width (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vb_reg),
        .num       ({xqb_reg, 26'd0}),
        .den       (derived.den),
        .in_side   ({ovfb_reg, sideb_reg}),
        .out_valid (v2),
        .quo       (w2),
        .out_side  (side2)
    );

    gpsb_exp_pipe #(
        .SIDE_W (26)
    ) u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (ve_reg),
        .y         (y_reg),
        .in_side   (sidee_reg),
        .out_valid (v3),
        .g         (g3),
        .out_side  (side3)
    );

    // sideg: [25:18] exponent, [17] width overflow, [16] out of range, [15:0] bin
    assign shift_amt = 9'd24 + 9'(sideg_reg[25:18]);
    assign shifted   = prod_reg >> shift_amt[5:0];

    always_comb
    begin
        if (sideg_reg[17] || sideg_reg[16] || (shift_amt >= 9'd64))
        begin
            amp_next = 32'd0;
        end
        else if (shifted[63:32] != 32'd0)
        begin
            amp_next = 32'hFFFF_FFFF;
        end
        else
        begin
            amp_next = shifted[31:0];
        end
    end

    assign push = adv & vg_reg;
    assign pop  = m_tvalid & m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            amp_buf_reg[wr_ptr_reg] <= amp_next;
            bin_buf_reg[wr_ptr_reg] <= sideg_reg[15:0];
            oor_buf_reg[wr_ptr_reg] <= sideg_reg[16];
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {bin_buf_reg[rd_ptr_reg], amp_buf_reg[rd_ptr_reg]};
    assign m_tuser  = oor_buf_reg[rd_ptr_reg];

endmodule

FILE: dv/tb_gaussian_peak_spectrum_bin.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_peak_spectrum_bin
// Self-checking bench for the Gaussian line-shape spectrum bin evaluator.
// Drives bin indexes with random gaps under several line and axis settings,
// predicts each bin in fixed point and checks amplitude, echo and flag in order.
// ----------------------------------------------------------------------------
module tb_gaussian_peak_spectrum_bin
    import gpsb_pkg::*;
;

    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED = 3'd7;

    typedef struct {
        logic [31:0] amplitude;
        logic [15:0] bin_echo;
        logic        out_of_range;
    } bin_result_t;

    class bin_scoreboard;
        bin_result_t pending[$];
        int errors = 0;
        logic [19:0] peak_energy;
        logic [15:0] peak_intensity;
        logic [15:0] fwhm_ref;
        logic [19:0] energy_top;
        logic [16:0] bin_count;

        function void reset_regs();
            peak_energy = RST_PEAK_ENERGY;
            peak_intensity = RST_PEAK_INTENSITY;
            fwhm_ref = RST_FWHM_REF;
            energy_top = RST_ENERGY_TOP;
            bin_count = RST_BIN_COUNT;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                IDX_PEAK_ENERGY: peak_energy = val;
                IDX_PEAK_INTENSITY: peak_intensity = val[15:0];
                IDX_FWHM_REF: fwhm_ref = val[15:0];
                IDX_ENERGY_TOP: energy_top = val;
                IDX_BIN_COUNT: bin_count = {1'b0, val[15:0]} | (val[16] ? 17'h10000 : 17'h0);
                default: ;
            endcase
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'h4000000000000000;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint unsigned exp_neg(longint unsigned y);
            logic [127:0] term;
            longint unsigned sum;
            sum = 64'h100000000;
            term = 128'h100000000;
            for (int k = 1; k <= 12; k++)
            begin
                term = ((term * y) >> 32) / k;
                if (k % 2 == 1)
                    sum -= term[63:0];
                else
                    sum += term[63:0];
            end
            return sum;
        endfunction

        function logic [31:0] density(longint unsigned bin, longint unsigned nb);
            longint unsigned e, f, c, p, xq, r, den, w, t16, n, q, g24, pk;
            logic [127:0] prod;
            e = (peak_energy != 0) ? peak_energy : 1;
            f = (fwhm_ref != 0) ? fwhm_ref : 1;
            c = (longint'(energy_top) * (2 * bin + 1) * 2048) / nb;
            p = e * 4096;
            xq = (c >= p) ? c - p : p - c;
            r = isqrt(e << 24);
            den = f * r;
            w = (xq << 26) / den;
            if (w >= (64'd1 << 18))
                return 0;
            t16 = (64'd42368 * w * w) >> 28;
            n = t16 >> 16;
            q = t16 & 16'hFFFF;
            g24 = exp_neg((q * 64'd2977044472) >> 16) >> 8;
            pk = ((64'd1584079 * peak_intensity) << 14) / den;
            if (24 + n >= 64)
                return 0;
            prod = (128'(pk) * g24) >> (24 + n);
            if (prod > 128'hFFFFFFFF)
                return 32'hFFFFFFFF;
            return prod[31:0];
        endfunction

        function void note_bin(logic [15:0] bin);
            bin_result_t res;
            longint unsigned nb;
            nb = (bin_count > 65536) ? 65536 : bin_count;
            res.bin_echo = bin;
            if (bin >= nb)
            begin
                res.amplitude = 0;
                res.out_of_range = 1;
            end
            else
            begin
                res.amplitude = density(bin, nb);
                res.out_of_range = 0;
            end
            pending.push_back(res);
        endfunction

        function void check_bin(logic [47:0] data, logic flag);
            bin_result_t exp_res;
            if (pending.size() == 0)
            begin
                $error("unexpected result bin=%0d", data[47:32]);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (data[31:0] !== exp_res.amplitude)
            begin
                $error("amplitude exp %0d got %0d", exp_res.amplitude, data[31:0]);
                errors++;
            end
            if (data[47:32] !== exp_res.bin_echo)
            begin
                $error("bin_echo exp %0d got %0d", exp_res.bin_echo, data[47:32]);
                errors++;
            end
            if (flag !== exp_res.out_of_range)
            begin
                $error("out_of_range exp %0d got %0d", exp_res.out_of_range, flag);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_wen = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [47:0] m_tdata;
    logic m_tuser;

    bin_scoreboard sb = new();

    gaussian_peak_spectrum_bin i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_wen(cfg_wen), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #1 clk = ~clk;

    initial
    begin
        #200000000;
        $display("FAIL gaussian_peak_spectrum_bin");
        $finish;
    end

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wen <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic send_bin(logic [15:0] bin, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 10) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= bin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_bin(bin);
    endtask

    task automatic random_bins(int count, int span, bit gaps);
        for (int i = 0; i < count; i++)
            send_bin((i % 8 == 0) ? 16'($urandom) : 16'($urandom_range(0, span)), gaps);
        s_tvalid <= 0;
    endtask

    task automatic set_line(int pe, int pi, int fw, int et, int bc);
        drain();
        write_cfg(IDX_PEAK_ENERGY, CFG_DATA_W'(pe));
        write_cfg(IDX_PEAK_INTENSITY, CFG_DATA_W'(pi));
        write_cfg(IDX_FWHM_REF, CFG_DATA_W'(fw));
        write_cfg(IDX_ENERGY_TOP, CFG_DATA_W'(et));
        write_cfg(IDX_BIN_COUNT, CFG_DATA_W'(bc));
        write_cfg(IDX_UNMAPPED, 20'hFFFFF);
        cfg_wen <= 0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_bin(m_tdata, m_tuser);
        end
    end

    initial
    begin
        int wait_cycles;
        forever
        begin
            wait_cycles = $urandom_range(0, 10);
            if (wait_cycles != 0)
            begin
                m_tready <= 0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_tready <= 1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        int limit;
        sb.reset_regs();
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_bin(16'd0, 0);
        send_bin(16'd1, 0);
        send_bin(16'd330, 0);
        send_bin(16'd331, 0);
        send_bin(16'd4095, 0);
        send_bin(16'd4096, 0);
        send_bin(16'hFFFF, 0);
        send_bin(16'h5555, 0);
        send_bin(16'hAAAA, 0);
        s_tvalid <= 0;
        set_line(0, 65535, 0, 1048575, 0);
        send_bin(16'd0, 0);
        send_bin(16'hFFFF, 0);
        s_tvalid <= 0;
        set_line(1048575, 65535, 65535, 1048575, 65536);
        send_bin(16'd0, 0);
        send_bin(16'hFFFF, 0);
        send_bin(16'h8000, 0);
        s_tvalid <= 0;
        set_line(1, 65535, 1, 1, 131071);
        send_bin(16'd0, 0);
        send_bin(16'hFFFF, 0);
        s_tvalid <= 0;
        set_line(100, 0, 300, 20000, 1);
        send_bin(16'd0, 0);
        send_bin(16'd1, 0);
        s_tvalid <= 0;
        set_line(int'(RST_PEAK_ENERGY), int'(RST_PEAK_INTENSITY), int'(RST_FWHM_REF),
                 int'(RST_ENERGY_TOP), int'(RST_BIN_COUNT));
        random_bins(100, 4095, 1);
        drain();
        random_bins(20, 4095, 0);
        set_line(5000, 65535, 4000, 16000, 256);
        random_bins(70, 300, 1);
        set_line(2000, 40000, 50, 4096, 128);
        random_bins(70, 140, 1);
        set_line($urandom_range(1, 1048575), $urandom_range(0, 65535),
                 $urandom_range(1, 65535), $urandom_range(1, 1048575),
                 $urandom_range(1, 65536));
        random_bins(70, 65535, 1);
        set_line(20000, 30000, 2000, 65536, 65536);
        random_bins(70, 65535, 1);
        limit = 0;
        while (sb.pending.size() != 0 && limit < 100000)
        begin
            @(posedge clk);
            limit++;
        end
        repeat (120) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS gaussian_peak_spectrum_bin");
        else
            $display("FAIL gaussian_peak_spectrum_bin");
        $finish;
    end
endmodule

FILE: sim.f
sv/gpsb_pkg.sv
sv/gpsb_div_pipe.sv
sv/gpsb_exp_pipe.sv
sv/gpsb_setup.sv
sv/gaussian_peak_spectrum_bin.sv
dv/tb_gaussian_peak_spectrum_bin.sv
